// File: hdl/mbet_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
`timescale 1ns / 1ps
`default_nettype none
package mbet_pkg;
    localparam int NUM_W = 23;
    localparam int MAG_W = 22;
    localparam logic [31:0] COLOR_STEP = 32'h0011_FF11;

    localparam logic [2:0] REG_CAM_X      = 3'd0;
    localparam logic [2:0] REG_CAM_Y      = 3'd1;
    localparam logic [2:0] REG_ZOOM       = 3'd2;
    localparam logic [2:0] REG_WIN_WIDTH  = 3'd3;
    localparam logic [2:0] REG_WIN_HEIGHT = 3'd4;
    localparam logic [2:0] REG_MAX_ITER   = 3'd5;

    typedef struct packed {
        logic signed [20:0] cam_x;
        logic signed [20:0] cam_y;
        logic [31:0]        zoom;
        logic [10:0]        win_width;
        logic [10:0]        win_height;
        logic [9:0]         max_iter;
    } cfg_t;
endpackage
`default_nettype wire

// File: hdl/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
// Usage:
//   Input channel (in_valid/in_stall) takes one pixel (pixel_x, pixel_y).
//   Output channel (out_valid/out_stall) returns iter_count and pixel_color
//   (iter_count * 0x11FF11 modulo 2^32), one result per pixel, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes cam_x,
//   cam_y, zoom, win_width, win_height, max_iter; cfg_ready is always high.
//   Write config only while no item is in flight.
// Operation:
//   Front end maps the pixel with two bit-serial dividers, after accepting it
//   and before handing it off to the queue.
//   Back end runs each escape iteration as four partial-product passes
//   through three half-width multipliers, then saturate and update.
//   A two-entry queue lets the front map the next pixels meanwhile.
// Reset loads the default registers and empties the queue.
// in_stall is high while the front maps a pixel or waits on a full queue.
// A stalled output holds its result; the back end waits, the front end keeps
// going until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_pixel #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       iter_count,
    output logic [31:0]      pixel_color,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int W = FRAC_BITS + 8;

    mbet_pkg::cfg_t  cfg_reg;
    logic            q_full, q_push, q_valid, q_pop;
    logic [2*W-1:0]  q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x      <= '0;
            cfg_reg.cam_y      <= '0;
            cfg_reg.zoom       <= 32'd6553600;
            cfg_reg.win_width  <= 11'd1000;
            cfg_reg.win_height <= 11'd1000;
            cfg_reg.max_iter   <= 10'd144;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mbet_pkg::REG_CAM_X:      cfg_reg.cam_x      <= cfg_data[20:0];
                mbet_pkg::REG_CAM_Y:      cfg_reg.cam_y      <= cfg_data[20:0];
                mbet_pkg::REG_ZOOM:       cfg_reg.zoom       <= cfg_data;
                mbet_pkg::REG_WIN_WIDTH:  cfg_reg.win_width  <= cfg_data[10:0];
                mbet_pkg::REG_WIN_HEIGHT: cfg_reg.win_height <= cfg_data[10:0];
                mbet_pkg::REG_MAX_ITER:   cfg_reg.max_iter   <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    mbet_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    mbet_fifo #(
        .DW (2*W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    mbet_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .iter_count  (iter_count),
        .pixel_color (pixel_color)
    );
endmodule
`default_nettype wire

// File: hdl/mbet_front.sv
// Front end: pixel to complex point mapping with bit-serial dividers.
`timescale 1ns / 1ps
`default_nettype none
module mbet_front #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 40
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mbet_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [9:0]         pixel_x,
    input  wire logic [9:0]         pixel_y,
    input  wire logic               q_full,
    output logic                    q_push,
    output logic [2*(FRAC_BITS+8)-1:0] q_data
);
    localparam int W     = FRAC_BITS + 8;
    localparam int NW    = mbet_pkg::NUM_W;
    localparam int MW    = mbet_pkg::MAG_W;
    localparam int NSTEP = MW + 15 + FRAC_BITS;
    localparam int CW    = $clog2(NSTEP);
    localparam logic [W-1:0] M = {1'b0, {(W-1){1'b1}}};

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic [31:0]   d_reg;
    logic [MW-1:0] shx_reg, shy_reg;
    logic [31:0]   rx_reg, ry_reg;
    logic [W-1:0]  qx_reg, qy_reg;
    logic          satx_reg, saty_reg, negx_reg, negy_reg;

    logic [31:0]          wd, hd, wc, hc;
    logic signed [NW-1:0] nx, ny;
    logic [32:0]          rx2, ry2;
    logic                 gex, gey;
    logic [W-1:0]         mx, my;

    always_comb
    begin
        wd = {21'b0, cfg.win_width};
        hd = {21'b0, cfg.win_height};
        wc = (wd > 32'(MAX_DIM)) ? 32'(MAX_DIM) : wd;
        hc = (hd > 32'(MAX_DIM)) ? 32'(MAX_DIM) : hd;
        nx = $signed({12'b0, pixel_x, 1'b0}) - $signed({{2{cfg.cam_x[20]}}, cfg.cam_x})
             - $signed(NW'(wc >> 2));
        ny = $signed({12'b0, pixel_y, 1'b0}) - $signed({{2{cfg.cam_y[20]}}, cfg.cam_y})
             - $signed(NW'(hc >> 2));
        rx2 = {rx_reg, shx_reg[MW-1]};
        ry2 = {ry_reg, shy_reg[MW-1]};
        gex = rx2 >= {1'b0, d_reg};
        gey = ry2 >= {1'b0, d_reg};
        mx  = (satx_reg || qx_reg[W-1]) ? M : qx_reg;
        my  = (saty_reg || qy_reg[W-1]) ? M : qy_reg;
        q_data = {(negx_reg ? -mx : mx), (negy_reg ? -my : my)};
    end

    assign in_stall = (state_reg != F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(NSTEP - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            d_reg    <= (cfg.zoom == 32'd0) ? 32'd1 : cfg.zoom;
            negx_reg <= nx[NW-1];
            negy_reg <= ny[NW-1];
            shx_reg  <= MW'(nx[NW-1] ? -nx : nx);
            shy_reg  <= MW'(ny[NW-1] ? -ny : ny);
            rx_reg   <= '0;
            ry_reg   <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
            satx_reg <= 1'b0;
            saty_reg <= 1'b0;
        end
        else if (state_reg == F_DIV)
        begin
            shx_reg  <= {shx_reg[MW-2:0], 1'b0};
            shy_reg  <= {shy_reg[MW-2:0], 1'b0};
            rx_reg   <= gex ? 32'(rx2 - {1'b0, d_reg}) : rx2[31:0];
            ry_reg   <= gey ? 32'(ry2 - {1'b0, d_reg}) : ry2[31:0];
            qx_reg   <= {qx_reg[W-2:0], gex};
            qy_reg   <= {qy_reg[W-2:0], gey};
            satx_reg <= satx_reg | qx_reg[W-1];
            saty_reg <= saty_reg | qy_reg[W-1];
        end
    end
endmodule
`default_nettype wire

// File: hdl/mbet_fifo.sv
// Two-entry queue between front end and escape-loop back end.
`timescale 1ns / 1ps
`default_nettype none
module mbet_fifo #(
    parameter int DW = 96
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] wdata,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output logic [DW-1:0]      rdata
);
    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end
endmodule
`default_nettype wire

// File: hdl/mbet_back.sv
// Back end: escape-time iteration with split fixed-point multipliers.
`timescale 1ns / 1ps
`default_nettype none
module mbet_back #(
    parameter int FRAC_BITS = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mbet_pkg::cfg_t        cfg,
    input  wire logic                  q_valid,
    input  wire logic [2*(FRAC_BITS+8)-1:0] q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [9:0]                 iter_count,
    output logic [31:0]                pixel_color
);
    localparam int W = FRAC_BITS + 8;
    localparam int H = (W + 1) / 2;
    localparam logic [W-1:0]        M    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W:0]   MP   = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0]   MN   = -MP;
    localparam logic [W:0]          FOUR = (W + 1)'(4) << FRAC_BITS;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CHK  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_FIN  = 3'd3;
    localparam logic [2:0] B_UPD  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]            state_reg;
    logic [1:0]            step_reg;
    logic [9:0]            cnt_reg;
    logic [31:0]           color_reg;
    logic signed [W-1:0]   cr_reg, ci_reg, zr_reg, zi_reg, sr_reg, si_reg, xy_reg;
    logic [2*H-1:0]        ar_reg, ai_reg;
    logic [4*H-1:0]        arr_reg, aii_reg, ari_reg;

    function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
        if (v > MP)
            return M;
        else if (v < MN)
            return -M;
        else
            return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] shsat(input logic [4*H-1:0] v);
        if (v > (4*H)'(M))
            return M;
        else
            return v[W-1:0];
    endfunction

    logic [H-1:0]        ar_i, ar_j, ai_j;
    logic [2*H-1:0]      p_rr, p_ii, p_ri;
    logic [4*H-1:0]      s_rr, s_ii, s_ri;
    logic [W-1:0]        u_rr, u_ii, u_ri;
    logic signed [W:0]   t_diff, t_r, t_i;
    logic signed [W-1:0] n_zr, n_zi;
    logic                esc;

    always_comb
    begin
        ar_i = step_reg[1] ? ar_reg[2*H-1:H] : ar_reg[H-1:0];
        ar_j = step_reg[0] ? ar_reg[2*H-1:H] : ar_reg[H-1:0];
        ai_j = step_reg[0] ? ai_reg[2*H-1:H] : ai_reg[H-1:0];
        p_rr = ar_i * ar_j;
        p_ii = (step_reg[1] ? ai_reg[2*H-1:H] : ai_reg[H-1:0]) * ai_j;
        p_ri = ar_i * ai_j;
        case (step_reg)
            2'd0:
            begin
                s_rr = (4*H)'(p_rr);
                s_ii = (4*H)'(p_ii);
                s_ri = (4*H)'(p_ri);
            end
            2'd3:
            begin
                s_rr = (4*H)'(p_rr) << (2*H);
                s_ii = (4*H)'(p_ii) << (2*H);
                s_ri = (4*H)'(p_ri) << (2*H);
            end
            default:
            begin
                s_rr = (4*H)'(p_rr) << H;
                s_ii = (4*H)'(p_ii) << H;
                s_ri = (4*H)'(p_ri) << H;
            end
        endcase
        u_rr = shsat(arr_reg >> FRAC_BITS);
        u_ii = shsat(aii_reg >> FRAC_BITS);
        u_ri = shsat(ari_reg >> (FRAC_BITS - 1));
        esc    = ({1'b0, sr_reg} + {1'b0, si_reg}) >= FOUR;
        t_diff = {sr_reg[W-1], sr_reg} - {si_reg[W-1], si_reg};
        n_zr   = sat(t_diff);
        t_r    = {n_zr[W-1], n_zr} + {cr_reg[W-1], cr_reg};
        t_i    = {xy_reg[W-1], xy_reg} + {ci_reg[W-1], ci_reg};
        n_zi   = sat(t_i);
    end

    assign q_pop       = (state_reg == B_IDLE) && q_valid;
    assign out_valid   = (state_reg == B_OUT);
    assign iter_count  = cnt_reg;
    assign pixel_color = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= 2'd0;
            cnt_reg   <= 10'd0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    cnt_reg <= 10'd0;
                    if (q_valid)
                        state_reg <= B_CHK;
                end
                B_CHK:
                begin
                    step_reg <= 2'd0;
                    if (cnt_reg < cfg.max_iter)
                        state_reg <= B_MUL;
                    else
                        state_reg <= B_OUT;
                end
                B_MUL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= B_FIN;
                end
                B_FIN: state_reg <= B_UPD;
                B_UPD:
                begin
                    if (esc)
                        state_reg <= B_OUT;
                    else
                    begin
                        cnt_reg   <= cnt_reg + 10'd1;
                        state_reg <= B_CHK;
                    end
                end
                B_OUT:
                begin
                    if (!out_stall)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= 32'(cnt_reg) * mbet_pkg::COLOR_STEP;
        case (state_reg)
            B_IDLE:
            begin
                cr_reg <= q_data[2*W-1:W];
                ci_reg <= q_data[W-1:0];
                zr_reg <= '0;
                zi_reg <= '0;
            end
            B_CHK:
            begin
                ar_reg  <= (2*H)'($unsigned(zr_reg[W-1] ? -zr_reg : zr_reg));
                ai_reg  <= (2*H)'($unsigned(zi_reg[W-1] ? -zi_reg : zi_reg));
                arr_reg <= '0;
                aii_reg <= '0;
                ari_reg <= '0;
            end
            B_MUL:
            begin
                arr_reg <= arr_reg + s_rr;
                aii_reg <= aii_reg + s_ii;
                ari_reg <= ari_reg + s_ri;
            end
            B_FIN:
            begin
                sr_reg <= u_rr;
                si_reg <= u_ii;
                xy_reg <= (zr_reg[W-1] ^ zi_reg[W-1]) ? -u_ri : u_ri;
            end
            B_UPD:
            begin
                if (!esc)
                begin
                    zr_reg <= sat(t_r);
                    zi_reg <= n_zi;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire
